### rtl/cfd_pkg.sv
package cfd_pkg;

    localparam logic [31:0] FLT_MAX_BITS32 = 32'h7F7F_FFFF;
    localparam logic [62:0] FLT_MAX_MAG64  = 63'h47EF_FFFF_E000_0000;
    localparam logic [10:0] EXP_ALL_ONES   = 11'h7FF;
    localparam logic [10:0] EXP_NORM_MIN   = 11'd897;
    localparam logic [10:0] EXP_BIAS_DIFF  = 11'd896;
    localparam logic [10:0] SUB_SHIFT_BASE = 11'd926;

    typedef struct packed {
        logic [31:0] value;
        logic        clamped;
    } t_lane_res;

endpackage

### rtl/cfd_if.sv
interface cfd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] real_in;
    logic [63:0] imag_in;
    logic        last_element;
    modport source (output valid, real_in, imag_in, last_element, input ready);
    modport sink   (input valid, real_in, imag_in, last_element, output ready);
endinterface

interface cfd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] real_out;
    logic [31:0] imag_out;
    logic        element_clamped;
    logic        array_overflow;
    logic        last_result;
    modport source (output valid, real_out, imag_out, element_clamped, array_overflow,
                    last_result, input ready);
    modport sink   (input valid, real_out, imag_out, element_clamped, array_overflow,
                    last_result, output ready);
endinterface

### rtl/cfd_lane.sv
module cfd_lane (
    input  logic [63:0]       i_x,
    output cfd_pkg::t_lane_res o_res
);
    logic        sign;
    logic [62:0] mag;
    logic [10:0] e;
    logic [51:0] m;
    logic [10:0] e_eff;
    logic [52:0] sig;
    logic [10:0] sh;
    logic [5:0]  sh6;
    logic [52:0] shifted;
    logic [52:0] rem;
    logic [52:0] half;
    logic [10:0] nexp;
    logic [22:0] nmant;
    logic [28:0] nrem;
    logic        nup;
    logic [30:0] nres;
    logic        sup;
    logic [30:0] sres;

    always_comb begin
        sign  = i_x[63];
        mag   = i_x[62:0];
        e     = i_x[62:52];
        m     = i_x[51:0];
        // Normal result: drop 29 mantissa bits with nearest-even rounding.
        nexp  = e - cfd_pkg::EXP_BIAS_DIFF;
        nmant = m[51:29];
        nrem  = m[28:0];
        nup   = nrem[28] && ((nrem[27:0] != 28'd0) || nmant[0]);
        nres  = {nexp[7:0], 23'd0} + {8'd0, nmant} + {30'd0, nup};
        // Subnormal or zero result.
        e_eff   = (e == 11'd0) ? 11'd1 : e;
        sig     = (e == 11'd0) ? {1'b0, m} : {1'b1, m};
        sh      = cfd_pkg::SUB_SHIFT_BASE - e_eff;
        sh6     = sh[5:0];
        shifted = sig >> sh6;
        rem     = sig & ((53'd1 << sh6) - 53'd1);
        half    = 53'd1 << (sh6 - 6'd1);
        sup     = (rem > half) || ((rem == half) && shifted[0]);
        sres    = shifted[30:0] + {30'd0, sup};
        o_res.clamped = 1'b0;
        if (e == cfd_pkg::EXP_ALL_ONES && m != 52'd0) begin
            o_res.value = {sign, 31'h7FC0_0000 | {8'd0, m[51:29]}};
        end else if (mag > cfd_pkg::FLT_MAX_MAG64) begin
            o_res.clamped = 1'b1;
            o_res.value   = {sign, cfd_pkg::FLT_MAX_BITS32[30:0]};
        end else if (e >= cfd_pkg::EXP_NORM_MIN) begin
            o_res.value = {sign, nres};
        end else if (sh >= 11'd54) begin
            o_res.value = {sign, 31'd0};
        end else begin
            o_res.value = {sign, sres};
        end
    end
endmodule

### rtl/complex_fp64_to_fp32_demote_top.sv
// Complex binary64 to binary32 saturating converter.
// The input channel carries one complex element per word: real and imaginary
// binary64 patterns and a last-of-array mark. The output channel returns one
// word per input word with both binary32 parts, a per-element clamp flag, the
// array overflow flag (valid on the last element) and the echoed last mark.
// Two identical conversion lanes handle the parts side by side; a merge
// stage ORs their clamp flags into the sticky array flag.
// Each result is registered: a word accepted in one cycle is offered in the next.
// Throughput is one word per cycle while the receiver is ready, set by the single output register.
// Input ready is high when the output register is empty or being drained,
// so a stalled receiver holds the result and back-pressures the source.
// Synchronous reset empties the output register and clears the sticky flag.
module complex_fp64_to_fp32_demote_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfd_in_if.sink        i_in,
    cfd_out_if.source     o_out
);
    cfd_pkg::t_lane_res re_res;
    cfd_pkg::t_lane_res im_res;
    logic r_valid, r_sticky, r_clamped, r_ovf, r_last;
    logic [31:0] r_re, r_im;
    logic acc, clamped, sticky;

    cfd_lane u_re (.i_x(i_in.real_in), .o_res(re_res));
    cfd_lane u_im (.i_x(i_in.imag_in), .o_res(im_res));

    assign i_in.ready = !r_valid || o_out.ready;
    assign acc        = i_in.valid && i_in.ready;
    assign clamped    = re_res.clamped || im_res.clamped;
    assign sticky     = r_sticky || clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_sticky <= 1'b0;
        end else begin
            if (acc) begin
                r_valid  <= 1'b1;
                r_sticky <= i_in.last_element ? 1'b0 : sticky;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_re      <= re_res.value;
            r_im      <= im_res.value;
            r_clamped <= clamped;
            r_ovf     <= i_in.last_element && sticky;
            r_last    <= i_in.last_element;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.real_out        = r_re;
    assign o_out.imag_out        = r_im;
    assign o_out.element_clamped = r_clamped;
    assign o_out.array_overflow  = r_ovf;
    assign o_out.last_result     = r_last;
endmodule

### sim/tb_complex_fp64_to_fp32_demote_top.sv
module tb_complex_fp64_to_fp32_demote_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] real_out;
        logic [31:0] imag_out;
        logic        element_clamped;
        logic        array_overflow;
        logic        last_result;
    } t_demoted;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cfd_in_if  in_ch ();
    cfd_out_if out_ch ();

    complex_fp64_to_fp32_demote_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    t_demoted   expected_words[$];
    logic       sticky_clamp = 1'b0;
    int         error_count = 0;
    int         idle_cycles = 0;
    bit         idle_src = 1'b1;
    bit         idle_sink = 1'b1;
    bit         hold_sink = 1'b0;
    bit         sink_paused = 1'b0;

    // Round right by sh bits, nearest even.
    function automatic logic [63:0] round_even(logic [63:0] sig, int sh);
        logic [63:0] r;
        logic [63:0] rem;
        logic [63:0] half;
        r    = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && r[0])) begin
            r = r + 64'd1;
        end
        return r;
    endfunction

    function automatic logic [31:0] demote_part(logic [63:0] x, ref logic clamped);
        logic [31:0] sgn;
        logic [62:0] mag;
        logic [10:0] ex;
        logic [51:0] man;
        int          e_eff;
        int          sh;
        logic [63:0] sig;
        sgn = {x[63], 31'd0};
        mag = x[62:0];
        ex  = x[62:52];
        man = x[51:0];
        if (ex == 11'h7FF && man != 0) begin
            return sgn | 32'h7FC0_0000 | 32'(man >> 29);
        end
        if (mag > 63'h47EF_FFFF_E000_0000) begin
            clamped = 1'b1;
            return sgn | 32'h7F7F_FFFF;
        end
        if (ex > 11'd896) begin
            return sgn | 32'((64'(ex - 11'd896) << 23) + round_even(64'(man), 29));
        end
        e_eff = (ex == 0) ? 1 : int'(ex);
        sig   = (ex == 0) ? 64'(man) : (64'(man) | (64'd1 << 52));
        sh    = 926 - e_eff;
        if (sh >= 54) begin
            return sgn;
        end
        return sgn | 32'(round_even(sig, sh));
    endfunction

    task automatic send_word(logic [63:0] re, logic [63:0] im, logic last);
        t_demoted exp_w;
        logic     clamped;
        clamped = 1'b0;
        exp_w.real_out = demote_part(re, clamped);
        exp_w.imag_out = demote_part(im, clamped);
        exp_w.element_clamped = clamped;
        exp_w.array_overflow  = last & (sticky_clamp | clamped);
        exp_w.last_result     = last;
        sticky_clamp = last ? 1'b0 : (sticky_clamp | clamped);
        while (idle_src && $urandom_range(99) < 26) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.real_in      <= re;
        in_ch.imag_in      <= im;
        in_ch.last_element <= last;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        expected_words.push_back(exp_w);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] random_double();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v[62:52] = 11'h7FF;
            1: v[62:52] = 11'(1150 + $urandom_range(4));
            2: v[62:52] = 11'(860 + $urandom_range(70));
            3: v[62:52] = 11'(897 + $urandom_range(253));
            4: v[62:52] = ($urandom_range(1)) ? 11'd0 : 11'(1 + $urandom_range(858));
            5: v = {v[63], 63'h47EF_FFFF_E000_0000 + 63'($urandom_range(2)) - 63'd1};
            default: ;
        endcase
        return v;
    endfunction

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic test_directed();
        send_word(64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0);
        send_word(64'h3FF0_0000_0000_0000, 64'hC000_0000_0000_0000, 1'b0);
        send_word(64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 1'b1);
        send_word(64'h7FF8_0000_0000_0001, 64'hFFF0_0000_0000_0001, 1'b0);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_word(64'h47EF_FFFF_E000_0000, 64'hC7EF_FFFF_E000_0000, 1'b1);
        send_word(64'h47EF_FFFF_E000_0001, 64'h47EF_FFFF_F000_0000, 1'b0);
        send_word(64'h3FF0_0000_1000_0000, 64'h3FF0_0000_3000_0000, 1'b0);
        send_word(64'h3FF0_0000_1000_0001, 64'h3FF0_0000_0FFF_FFFF, 1'b1);
        send_word(64'h3810_0000_0000_0000, 64'h380F_FFFF_FFFF_FFFF, 1'b0);
        send_word(64'h36A0_0000_0000_0000, 64'h3690_0000_0000_0001, 1'b0);
        send_word(64'h3690_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b1);
        send_word(64'h7FEF_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000, 1'b0);
        send_word(64'h36A8_0000_0000_0000, 64'hB6A8_0000_0000_0001, 1'b1);
        send_word(64'hFFFF_FFFF_FFFF_FFFE, 64'h5555_5555_5555_5555, 1'b1);
        send_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h0, 1'b1);
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) begin
            send_word(random_double(), random_double(), $urandom_range(7) == 0);
        end
    endtask

    // No idling on either side for a stretch.
    task automatic test_full_rate(int n);
        idle_src  = 1'b0;
        idle_sink = 1'b0;
        test_random(n);
        idle_src  = 1'b1;
        idle_sink = 1'b1;
    endtask

    // Receiver holds off while words keep coming, so the block stalls its input.
    task automatic test_backpressure();
        hold_sink = 1'b1;
        test_random(20);
        in_ch.valid <= 1'b0;
        wait (!hold_sink);
    endtask

    // Sender pauses until every word has come back.
    task automatic test_drain_pause();
        test_random(30);
        wait_drained();
        test_random(30);
    endtask

    always @(negedge i_clk) begin
        if (hold_sink && !sink_paused) begin
            sink_paused = 1'b1;
            for (int k = 0; k < 60; k++) begin
                @(negedge i_clk);
            end
            hold_sink   = 1'b0;
            sink_paused = 1'b0;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= !hold_sink && !(idle_sink && $urandom_range(99) < 26);
    end

    always @(posedge i_clk) begin
        t_demoted exp_w;
        t_demoted got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.real_out, out_ch.imag_out, out_ch.element_clamped,
                   out_ch.array_overflow, out_ch.last_result};
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                error_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (got.real_out !== exp_w.real_out)
                    $display("%0t: real_out exp %h got %h", $time, exp_w.real_out,
                             got.real_out);
                if (got.imag_out !== exp_w.imag_out)
                    $display("%0t: imag_out exp %h got %h", $time, exp_w.imag_out,
                             got.imag_out);
                if (got.element_clamped !== exp_w.element_clamped)
                    $display("%0t: element_clamped exp %b got %b", $time,
                             exp_w.element_clamped, got.element_clamped);
                if (got.array_overflow !== exp_w.array_overflow)
                    $display("%0t: array_overflow exp %b got %b", $time,
                             exp_w.array_overflow, got.array_overflow);
                if (got.last_result !== exp_w.last_result)
                    $display("%0t: last_result exp %b got %b", $time,
                             exp_w.last_result, got.last_result);
                if (got !== exp_w) error_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.real_in      = '0;
        in_ch.imag_in      = '0;
        in_ch.last_element = 1'b0;
        out_ch.ready       = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(600);
        test_backpressure();
        test_full_rate(300);
        test_drain_pause();
        test_random(400);
        wait_drained();
        repeat (10) @(negedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

### files.f
rtl/cfd_pkg.sv
rtl/cfd_if.sv
rtl/cfd_lane.sv
rtl/complex_fp64_to_fp32_demote_top.sv
sim/tb_complex_fp64_to_fp32_demote_top.sv
